@@ rtl/tlbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbs_pkg
// shared constants, request codes and interface types for the table search
// ----------------------------------------------------------------------------
package tlbs_pkg;

	// table geometry
	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// configuration register width (entry_count)
	localparam int CFG_W  = 11;
	localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	// request codes carried on req_type
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LINEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_BINARY = 2'd2;

	// one table access per cycle
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	// search outcome handed to the output register
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] pos;
	} res_t;

endpackage

@@ rtl/table_linear_and_binary_search.sv @@
// ----------------------------------------------------------------------------
// table_linear_and_binary_search
// 1024 x 32-bit signed word table with write, linear search and halving search
// ----------------------------------------------------------------------------
// write: no result word; linear search: one table read per entry over the n
//   used entries, stopping early on a match; halving search: one table read
//   per probe, at most ceil(log2(n+1)) probes
// throughput: one item at a time, bound by the single ram port (one read or
//   write per cycle); the next item is taken once the result leaves the engine
// reset: control and entry_count clear at once, table contents undefined
module table_linear_and_binary_search
	import tlbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration: entry_count
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] slot,
	input  logic [DATA_W-1:0] word,
	input  logic [DATA_W-1:0] key,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic              hit,
	output logic [ADDR_W-1:0] hit_position
);

	// number of entries searched, clamped to the table size in the engine
	logic [CFG_W-1:0]  entry_count_q;

	// engine to ram
	mem_req_t          mem;
	logic [DATA_W-1:0] rdata;

	// engine to output register
	logic              eng_valid;
	res_t              eng_res;
	logic              eng_ready;

	// output register, parts the engine from the result consumer
	logic              out_valid_q;
	res_t              out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// the table itself: one port, read data registered in the cycle after the address
	tlbs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem.we),
		.re   (mem.re),
		.addr (mem.addr),
		.wdata(mem.wdata),
		.rdata(rdata)
	);

	// sequencer: writes go straight to the table, searches walk it
	tlbs_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.slot       (slot),
		.word       (word),
		.key        (key),
		.entry_count(entry_count_q),
		.mem        (mem),
		.rdata      (rdata),
		.res_valid  (eng_valid),
		.res        (eng_res),
		.res_ready  (eng_ready)
	);

	// engine hands off when the register is empty or drains this cycle
	assign eng_ready = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (eng_valid && eng_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= eng_res;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = out_valid_q;
	assign hit          = out_q.hit;
	assign hit_position = out_q.pos;

`ifndef SYNTHESIS
	// a search keeps the request side stalled in the following cycle
	a_search_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req_type == REQ_LINEAR || req_type == REQ_BINARY))
		|=> req_stall)
		else $error("search accepted without stalling the next request");

	// a hit lies inside the searched range
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && hit) |-> ({1'b0, hit_position} < entry_count_q))
		else $error("hit position beyond entry_count");

	// a miss reports position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !hit) |-> (hit_position == '0))
		else $error("miss with nonzero position");

	// the engine never hands off into a full, stalled output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("output register overwritten while stalled");
`endif

endmodule

@@ rtl/tlbs_ram.sv @@
// ----------------------------------------------------------------------------
// tlbs_ram
// single-port synchronous ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module tlbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/tlbs_engine.sv @@
// ----------------------------------------------------------------------------
// tlbs_engine
// search sequencer: takes requests, drives the table ram, walks linear and
// halving searches and holds the outcome until the output side takes it
// ----------------------------------------------------------------------------
module tlbs_engine
	import tlbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] slot,
	input  logic [DATA_W-1:0] word,
	input  logic [DATA_W-1:0] key,
	input  logic [CFG_W-1:0]  entry_count,
	output mem_req_t          mem,
	input  logic [DATA_W-1:0] rdata,
	output logic              res_valid,
	output res_t              res,
	input  logic              res_ready
);

	typedef enum logic [1:0] {ST_IDLE, ST_LIN, ST_BIN, ST_DONE} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  he_q;
	logic              rd_pend_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	res_t              res_q;

	logic              accept;
	logic [CMP_W-1:0]  cnt_ext;
	logic [CNT_W-1:0]  used;
	logic              match;
	logic              key_gt;
	logic [CNT_W-1:0]  lo_nx;
	logic [CNT_W-1:0]  he_nx;
	logic [CNT_W:0]    mid_sum;
	logic [ADDR_W-1:0] mid_nx;
	logic              lin_more;
	logic              bin_more;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// count clamped to the table size
	assign cnt_ext = CMP_W'(entry_count);
	assign used    = (cnt_ext > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cnt_ext);

	// compare against the word read last cycle
	assign match  = rd_pend_s1 && (rdata == key_q);
	assign key_gt = $signed(key_q) > $signed(rdata);

	// halving bounds, range is [lo, he)
	always_comb begin
		lo_nx = lo_q;
		he_nx = he_q;
		if (rd_pend_s1 && !match) begin
			if (key_gt) begin
				lo_nx = CNT_W'(rd_idx_s1) + CNT_W'(1);
			end else begin
				he_nx = CNT_W'(rd_idx_s1);
			end
		end
	end

	assign mid_sum  = {1'b0, lo_nx} + {1'b0, he_nx} - (CNT_W+1)'(1);
	assign mid_nx   = mid_sum[ADDR_W:1];
	assign bin_more = lo_nx < he_nx;
	assign lin_more = idx_q < n_q;

	always_comb begin
		mem.we    = 1'b0;
		mem.re    = 1'b0;
		mem.addr  = slot;
		mem.wdata = word;
		unique case (state_q)
			ST_IDLE: begin
				mem.we = accept && (req_type == REQ_WRITE);
			end
			ST_LIN: begin
				mem.re   = !match && lin_more;
				mem.addr = idx_q[ADDR_W-1:0];
			end
			ST_BIN: begin
				mem.re   = !match && bin_more;
				mem.addr = mid_nx;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= mem.re;
			rd_idx_s1  <= mem.addr;
			unique case (state_q)
				ST_IDLE: begin
					key_q <= key;
					n_q   <= used;
					idx_q <= '0;
					lo_q  <= '0;
					he_q  <= used;
					if (accept) begin
						priority if (req_type == REQ_LINEAR) begin
							state_q <= ST_LIN;
						end else if (req_type == REQ_BINARY) begin
							state_q <= ST_BIN;
						end else begin
							// writes and unknown codes finish here
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LIN: begin
					if (match) begin
						res_q.hit <= 1'b1;
						res_q.pos <= rd_idx_s1;
						state_q   <= ST_DONE;
					end else if (lin_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end else begin
						res_q.hit <= 1'b0;
						res_q.pos <= '0;
						state_q   <= ST_DONE;
					end
				end
				ST_BIN: begin
					lo_q <= lo_nx;
					he_q <= he_nx;
					if (match) begin
						res_q.hit <= 1'b1;
						res_q.pos <= rd_idx_s1;
						state_q   <= ST_DONE;
					end else if (!bin_more) begin
						res_q.hit <= 1'b0;
						res_q.pos <= '0;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks the table search block: table writes, linear and halving searches
// against a shadow copy of the table, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench
	import tlbs_pkg::*;
();

	// the limit sits well above the length of the run, with slow linear searches
	// over the full table and receiver stalls included
	localparam int LIMIT_CYCLES = 2000000;
	// writes land in the table at the edge they are taken, a short pause covers them
	localparam int DRAIN_CYCLES = 8;
	// long receiver hold-off so the block backs up into its input
	localparam int HOLD_CYCLES  = 300;
	localparam int CHUNKS       = 22;
	localparam int CHUNK_WORDS  = 25;
	localparam int CNT_BEYOND   = 2047;

	// request code the block drops without a result
	localparam logic [REQ_W-1:0]  REQ_NONE    = 2'd3;
	localparam logic [DATA_W-1:0] INT_LOWEST  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_HIGHEST = 32'h7fff_ffff;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [ADDR_W-1:0] slot;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] key;
	} request_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              cfg_wr_en    = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data  = '0;
	logic              req_valid    = 1'b0;
	logic              req_stall;
	logic [REQ_W-1:0]  req_type     = REQ_WRITE;
	logic [ADDR_W-1:0] slot         = '0;
	logic [DATA_W-1:0] word         = '0;
	logic [DATA_W-1:0] key          = '0;
	logic              res_valid;
	logic              res_stall    = 1'b0;
	logic              hit;
	logic [ADDR_W-1:0] hit_position;

	// words waiting to be offered, and search answers waiting to come out
	request_t          request_backlog[$];
	res_t              lookup_answers[$];

	// shadow of the block state, updated as words are taken
	logic [DATA_W-1:0] shadow_table [DEPTH];
	int                shadow_count  = 0;

	int                pushed_count  = 0;
	int                taken_count   = 0;
	int                fail_count    = 0;
	int                cycle_count   = 0;
	int                send_idle_pct = 30;
	int                recv_idle_pct = 54;
	logic              hold_arm      = 1'b0;
	logic              hold_done     = 1'b0;
	int                hold_left     = 0;

	table_linear_and_binary_search uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.slot         (slot),
		.word         (word),
		.key          (key),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.hit          (hit),
		.hit_position (hit_position)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// search answer over the entries in use
	function automatic res_t lookup_result(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] k);
		res_t r;
		int   n_used;
		int   lo;
		int   hi;
		int   mid;
		int   i;
		r = '0;
		// counts above the table depth clamp to the whole table
		n_used = (shadow_count > DEPTH) ? DEPTH : shadow_count;
		if (kind == REQ_LINEAR) begin
			for (i = 0; i < n_used; i++) begin
				if (shadow_table[i] == k) begin
					r.hit = 1'b1;
					r.pos = ADDR_W'(i);
					return r;
				end
			end
		end else begin
			// halving probe, stops at the first midpoint that matches,
			// follows the probe rule even when the table is out of order
			lo = 0;
			hi = n_used - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (shadow_table[mid] == k) begin
					r.hit = 1'b1;
					r.pos = ADDR_W'(mid);
					return r;
				end
				if ($signed(k) > $signed(shadow_table[mid]))
					lo = mid + 1;
				else
					hi = mid - 1;
			end
		end
		return r;
	endfunction

	// a word was taken by the block: update the shadow or expect an answer
	function automatic void apply_request(request_t r);
		if (r.kind == REQ_WRITE)
			shadow_table[r.slot] = r.value;
		else if (r.kind == REQ_LINEAR || r.kind == REQ_BINARY)
			lookup_answers.push_back(lookup_result(r.kind, r.key));
		// unknown request code: dropped, nothing expected
	endfunction

	function automatic void queue_request(logic [REQ_W-1:0] kind, int s,
			logic [DATA_W-1:0] v, logic [DATA_W-1:0] k);
		request_t r;
		r.kind  = kind;
		r.slot  = ADDR_W'(s);
		r.value = v;
		r.key   = k;
		request_backlog.push_back(r);
		pushed_count++;
	endfunction

	// wait until every queued word is taken and every answer has come out
	task automatic settle();
		while (taken_count != pushed_count || lookup_answers.size() != 0)
			@(posedge clk);
		// a short pause before the next step
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// entry_count register write, only while the block is idle
	task automatic write_count(int n);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(n);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_count = n;
	endtask

	// request driver: holds a word until taken, then offers the next one
	always @(posedge clk) begin
		request_t pick;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				apply_request(request_t'({req_type, slot, word, key}));
				taken_count++;
			end
			if (!req_valid || !req_stall) begin
				// idle decision never looks at stall
				if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					pick = request_backlog.pop_front();
					req_valid <= 1'b1;
					req_type  <= pick.kind;
					slot      <= pick.slot;
					word      <= pick.value;
					key       <= pick.key;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (lookup_answers.size() == 0) begin
					$display("%0t: result with nothing expected, hit %0b position %0d",
						$time, hit, hit_position);
					fail_count++;
				end else begin
					want = lookup_answers.pop_front();
					if (hit !== want.hit) begin
						$display("%0t: hit mismatch, expected %0b actual %0b",
							$time, want.hit, hit);
						fail_count++;
					end
					if (hit_position !== want.pos) begin
						$display("%0t: hit_position mismatch, expected %0d actual %0d",
							$time, want.pos, hit_position);
						fail_count++;
					end
				end
			end
			// long hold-off counted here, once; otherwise random stalls
			if (hold_arm && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		longint fill;
		longint lo;
		longint hi;
		int     chunk;
		int     n;
		int     n_used;
		int     r;
		int     s;
		int     kk;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] k;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero count: searches read nothing and always miss
		write_count(0);
		queue_request(REQ_LINEAR, 0, '0, '0);
		queue_request(REQ_BINARY, $urandom_range(0, DEPTH - 1), $urandom, INT_LOWEST);
		// unknown request code with every bit set, dropped
		queue_request(REQ_NONE, DEPTH - 1, '1, '1);
		settle();

		// fill the whole table ascending, lowest value first and highest last,
		// with runs of equal values along the way
		fill = -64'sd2147483648;
		for (s = 0; s < DEPTH; s++) begin
			if (s == DEPTH - 1)
				fill = 64'sd2147483647;
			else if (s > 0)
				fill += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4000000);
			queue_request(REQ_WRITE, s, fill[DATA_W-1:0], $urandom);
		end
		settle();

		// full table: both ends, a middle value, near misses
		write_count(DEPTH);
		queue_request(REQ_LINEAR, 0, '0, INT_LOWEST);
		queue_request(REQ_LINEAR, 0, '0, INT_HIGHEST);
		queue_request(REQ_LINEAR, 0, '0, shadow_table[DEPTH/2] + 1);
		queue_request(REQ_BINARY, 0, '0, INT_LOWEST);
		queue_request(REQ_BINARY, 0, '0, INT_HIGHEST);
		queue_request(REQ_BINARY, 0, '0, shadow_table[DEPTH/2 - 1]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[DEPTH/2] + 1);
		queue_request(REQ_BINARY, 0, '0, shadow_table[3] - 1);
		settle();

		// count beyond the table clamps to the table depth
		write_count(CNT_BEYOND);
		queue_request(REQ_LINEAR, 0, '0, shadow_table[DEPTH - 1]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[DEPTH - 2]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[0]);
		settle();

		// one and two entries in use
		write_count(1);
		queue_request(REQ_LINEAR, 0, '0, shadow_table[0]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[0]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[1] + 1);
		settle();
		write_count(2);
		queue_request(REQ_LINEAR, 0, '0, shadow_table[1]);
		queue_request(REQ_BINARY, 0, '0, shadow_table[1]);
		settle();

		// random part, a count setting per chunk; idling swaps between thirds
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			send_idle_pct = (chunk < 7) ? 30 : (chunk < 14) ? 54 : 0;
			recv_idle_pct = (chunk < 7) ? 54 : (chunk < 14) ? 30 : 0;
			if (chunk % 7 == 0) begin
				r = $urandom_range(0, 2);
				n = (r == 0) ? DEPTH - 1 : (r == 1) ? DEPTH : CNT_BEYOND;
			end else if (chunk == 3) begin
				n = 0;
			end else begin
				n = $urandom_range(1, 48);
			end
			write_count(n);
			n_used = (n > DEPTH) ? DEPTH : n;

			repeat (CHUNK_WORDS) begin
				r = $urandom_range(0, 99);
				// search key: mostly a stored value, sometimes a neighbor or noise
				kk = $urandom_range(0, 99);
				if (n_used > 0 && kk < 70)
					k = shadow_table[$urandom_range(0, n_used - 1)];
				else if (n_used > 0 && kk < 85)
					k = shadow_table[$urandom_range(0, n_used - 1)]
						+ ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
				else
					k = $urandom;
				if (r < 3) begin
					queue_request(REQ_NONE, $urandom_range(0, DEPTH - 1), $urandom, $urandom);
				end else if (r < 23) begin
					// writes land mostly near the used range
					if ($urandom_range(0, 9) < 7)
						s = $urandom_range(0, (n_used + 3 > DEPTH - 1) ? DEPTH - 1 : n_used + 3);
					else
						s = $urandom_range(0, DEPTH - 1);
					// mostly keep the order between neighbors, else any value
					lo = (s > 0) ? longint'($signed(shadow_table[s - 1])) : -64'sd2147483648;
					hi = (s < DEPTH - 1) ? longint'($signed(shadow_table[s + 1]))
						: 64'sd2147483647;
					if ($urandom_range(0, 3) != 0 && lo <= hi)
						v = DATA_W'(lo + (longint'($urandom) % (hi - lo + 1)));
					else
						v = $urandom;
					queue_request(REQ_WRITE, s, v, $urandom);
				end else if (r < 62) begin
					queue_request(REQ_LINEAR, $urandom_range(0, DEPTH - 1), $urandom, k);
				end else begin
					queue_request(REQ_BINARY, $urandom_range(0, DEPTH - 1), $urandom, k);
				end
			end

			// sender keeps offering while the receiver sits on a long hold-off
			if (chunk == 15)
				hold_arm <= 1'b1;
			settle();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
